FILE: hw/rtl/wmes_pkg.sv
// shared types, constants and lookup functions for the wasm memory export scanner
// no dependencies; imported by the top level and the bench
`default_nettype none

package wmes_pkg;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_SEC_ID    = 4'd1,
        PH_SEC_LEN   = 4'd2,
        PH_MEM_COUNT = 4'd3,
        PH_EXP_COUNT = 4'd4,
        PH_NAME_LEN  = 4'd5,
        PH_NAME      = 4'd6,
        PH_KIND      = 4'd7,
        PH_INDEX     = 4'd8,
        PH_SKIP      = 4'd9,
        PH_HALT      = 4'd10
    } phase_t;

    // result flag bit positions
    localparam int FL_OWNS     = 0;
    localparam int FL_EXPORTED = 1;
    localparam int FL_FOUND    = 2;
    localparam int FL_HEADER   = 3;

    localparam logic [7:0] SEC_ID_MEMORY = 8'h05;
    localparam logic [7:0] SEC_ID_EXPORT = 8'h07;
    localparam logic [7:0] KIND_MEMORY   = 8'h02;
    localparam logic [7:0] LEB_CONT      = 8'h80;
    localparam logic [7:0] LEB_PAYLOAD   = 8'h7F;
    localparam logic [31:0] NAME_LENGTH  = 32'd6;
    localparam logic [5:0] LEB_LIMIT     = 6'd32;
    localparam logic [5:0] LEB_STEP      = 6'd7;

    typedef struct packed {
        logic [31:0] acc;
        logic [5:0]  shift;
    } leb_t;

    // header bytes 00 61 73 6d 01 00 00 00
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd1:    v = 8'h61;
            3'd2:    v = 8'h73;
            3'd3:    v = 8'h6D;
            3'd4:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // characters of the export name "memory"
    function automatic logic [7:0] name_char(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h6D;
            3'd1:    v = 8'h65;
            3'd2:    v = 8'h6D;
            3'd3:    v = 8'h6F;
            3'd4:    v = 8'h72;
            default: v = 8'h79;
        endcase
        return v;
    endfunction

    // one unsigned leb128 byte into the accumulator, saturating at 32 bits
    function automatic leb_t leb_feed(input leb_t cur, input logic [7:0] b);
        leb_t        r;
        logic [39:0] t;
        r = cur;
        t = 40'(cur.acc) | (40'(b & LEB_PAYLOAD) << cur.shift);
        if (cur.shift < LEB_LIMIT)
        begin
            r.acc   = (t[39:32] != 8'd0) ? 32'hFFFF_FFFF : t[31:0];
            r.shift = cur.shift + LEB_STEP;
        end
        else if ((b & LEB_PAYLOAD) != 8'd0)
        begin
            r.acc = 32'hFFFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wmes_byte_if.sv
// byte request channel of the scanner: valid, ready, data byte and last marker
// no dependencies
`default_nettype none

interface wmes_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wmes_summary_if.sv
// summary request channel of the scanner: valid, ready and the module summary
// no dependencies
`default_nettype none

interface wmes_summary_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic        owns_memory;
    logic        memory_exported;
    logic        patch_needed;
    logic        export_section_found;
    logic [31:0] export_section_start;
    logic [31:0] export_payload_start;
    logic [31:0] export_payload_length;
    logic [31:0] export_entry_count;

    modport source (
        output valid, input ready,
        output header_ok, output owns_memory, output memory_exported, output patch_needed,
        output export_section_found, output export_section_start,
        output export_payload_start, output export_payload_length, output export_entry_count
    );
    modport sink (
        input valid, output ready,
        input header_ok, input owns_memory, input memory_exported, input patch_needed,
        input export_section_found, input export_section_start,
        input export_payload_start, input export_payload_length, input export_entry_count
    );
endinterface

`default_nettype wire

FILE: hw/rtl/wasm_memory_export_scanner.sv
// wasm memory export scanner: one byte per cycle while input is ready, one summary per module on the last byte
// a summary is valid the cycle after its last byte is accepted
// throughput: one byte per cycle while input is ready; parse state updates once per accepted byte
// a byte is taken while the summary register is empty or being drained
// reset: rst_n async low clears parse state and the summary valid bit
// depends on wmes_pkg, wmes_byte_if, wmes_summary_if
`default_nettype none

module wasm_memory_export_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  wire             clk,
    input  wire             rst_n,
    wmes_byte_if.sink       in_bytes,
    wmes_summary_if.source  summary
);
    import wmes_pkg::*;

    localparam int SUM_BITS = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    function automatic logic [31:0] low32(input logic [OFFSET_BITS-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[31:0];
    endfunction

    logic [OFFSET_BITS-1:0] pos_reg,        pos_next;
    phase_t                 phase_reg,      phase_next;
    logic                   hdr_match_reg,  hdr_match_next;
    leb_t                   leb_reg,        leb_next;
    logic [7:0]             sec_id_reg,     sec_id_next;
    logic [OFFSET_BITS-1:0] sec_end_reg,    sec_end_next;
    logic [31:0]            entries_reg,    entries_next;
    logic [31:0]            name_left_reg,  name_left_next;
    logic                   name_match_reg, name_match_next;
    logic [3:0]             flags_reg,      flags_next;
    logic [OFFSET_BITS-1:0] rec_start_reg,  rec_start_next;
    logic [OFFSET_BITS-1:0] rec_pay_reg,    rec_pay_next;
    logic [31:0]            rec_len_reg,    rec_len_next;
    logic [31:0]            rec_cnt_reg,    rec_cnt_next;
    logic                   out_valid_reg;

    logic                   in_accept;
    phase_t                 phase_eff;
    leb_t                   feed;
    logic                   leb_done;
    logic [OFFSET_BITS-1:0] pos_plus1;
    logic [SUM_BITS-1:0]    end_sum;
    logic [OFFSET_BITS-1:0] end_sat;
    logic                   hdr_now;

    logic                   res_hdr, res_owns, res_exp, res_found;

    assign in_bytes.ready = !out_valid_reg || summary.ready;
    assign in_accept      = in_bytes.valid && in_bytes.ready;

    assign feed      = leb_feed(leb_reg, in_bytes.data_byte);
    assign leb_done  = (in_bytes.data_byte & LEB_CONT) == 8'd0;
    assign pos_plus1 = (pos_reg == POS_MAX) ? pos_reg : pos_reg + OFFSET_BITS'(1);
    assign end_sum   = SUM_BITS'(pos_plus1) + SUM_BITS'(feed.acc);
    assign end_sat   = (end_sum > SUM_BITS'(POS_MAX)) ? POS_MAX : end_sum[OFFSET_BITS-1:0];
    assign hdr_now   = hdr_match_reg &&
                       !((pos_reg < OFFSET_BITS'(8)) &&
                         (in_bytes.data_byte != magic_byte(pos_reg[2:0])));

    // body phases fall back to section id once the declared section end is reached
    always_comb
    begin
        phase_eff = phase_reg;
        if (phase_reg >= PH_MEM_COUNT && phase_reg <= PH_SKIP && pos_reg >= sec_end_reg)
            phase_eff = PH_SEC_ID;
    end

    // next parse state
    always_comb
    begin
        pos_next        = pos_plus1;
        phase_next      = phase_eff;
        hdr_match_next  = hdr_match_reg;
        leb_next        = leb_reg;
        sec_id_next     = sec_id_reg;
        sec_end_next    = sec_end_reg;
        entries_next    = entries_reg;
        name_left_next  = name_left_reg;
        name_match_next = name_match_reg;
        flags_next      = flags_reg;
        rec_start_next  = rec_start_reg;
        rec_pay_next    = rec_pay_reg;
        rec_len_next    = rec_len_reg;
        rec_cnt_next    = rec_cnt_reg;

        unique case (phase_eff)
            PH_HEADER:
            begin
                hdr_match_next = hdr_now;
                if (pos_reg >= OFFSET_BITS'(7))
                begin
                    if (hdr_now)
                    begin
                        flags_next[FL_HEADER] = 1'b1;
                        phase_next            = PH_SEC_ID;
                    end
                    else
                    begin
                        phase_next = PH_HALT;
                    end
                end
            end
            PH_SEC_ID:
            begin
                // an id on the final byte cannot start a section
                if (!in_bytes.last_byte)
                begin
                    sec_id_next = in_bytes.data_byte;
                    leb_next    = '0;
                    phase_next  = PH_SEC_LEN;
                    if (in_bytes.data_byte == SEC_ID_EXPORT)
                    begin
                        flags_next[FL_FOUND] = 1'b1;
                        rec_start_next       = pos_reg;
                        rec_pay_next         = pos_plus1;
                        rec_len_next         = '0;
                        rec_cnt_next         = '0;
                    end
                end
            end
            PH_SEC_LEN:
            begin
                leb_next = feed;
                if (sec_id_reg == SEC_ID_EXPORT)
                begin
                    rec_pay_next = pos_plus1;
                    rec_len_next = feed.acc;
                end
                if (leb_done)
                begin
                    sec_end_next = end_sat;
                    leb_next     = '0;
                    if (sec_id_reg == SEC_ID_MEMORY)
                        phase_next = PH_MEM_COUNT;
                    else if (sec_id_reg == SEC_ID_EXPORT)
                        phase_next = PH_EXP_COUNT;
                    else
                        phase_next = PH_SKIP;
                end
            end
            PH_MEM_COUNT:
            begin
                if ((in_bytes.data_byte & LEB_PAYLOAD) != 8'd0)
                    flags_next[FL_OWNS] = 1'b1;
                leb_next = feed;
                if (leb_done)
                    phase_next = PH_SKIP;
            end
            PH_EXP_COUNT:
            begin
                leb_next     = feed;
                rec_cnt_next = feed.acc;
                if (leb_done)
                begin
                    entries_next = feed.acc;
                    phase_next   = (feed.acc == 32'd0) ? PH_SKIP : PH_NAME_LEN;
                    leb_next     = '0;
                end
            end
            PH_NAME_LEN:
            begin
                leb_next = feed;
                if (leb_done)
                begin
                    name_left_next  = feed.acc;
                    name_match_next = (feed.acc == NAME_LENGTH);
                    phase_next      = (feed.acc == 32'd0) ? PH_KIND : PH_NAME;
                    leb_next        = '0;
                end
            end
            PH_NAME:
            begin
                if (name_match_reg && name_left_reg >= 32'd1 && name_left_reg <= NAME_LENGTH &&
                    in_bytes.data_byte != name_char(3'(NAME_LENGTH[2:0] - name_left_reg[2:0])))
                    name_match_next = 1'b0;
                name_left_next = name_left_reg - 32'd1;
                if (name_left_reg == 32'd1)
                    phase_next = PH_KIND;
            end
            PH_KIND:
            begin
                if (name_match_reg && in_bytes.data_byte == KIND_MEMORY)
                begin
                    flags_next[FL_EXPORTED] = 1'b1;
                    phase_next              = PH_SKIP;
                end
                else
                begin
                    phase_next = PH_INDEX;
                    leb_next   = '0;
                end
            end
            PH_INDEX:
            begin
                leb_next = feed;
                if (leb_done)
                begin
                    entries_next = entries_reg - 32'd1;
                    phase_next   = (entries_reg == 32'd1) ? PH_SKIP : PH_NAME_LEN;
                    leb_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // summary fields from the updated flags
    always_comb
    begin
        res_hdr   = flags_next[FL_HEADER];
        res_owns  = res_hdr && flags_next[FL_OWNS];
        res_exp   = res_hdr && flags_next[FL_EXPORTED];
        res_found = res_hdr && flags_next[FL_FOUND];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_HEADER;
            hdr_match_reg  <= 1'b1;
            leb_reg        <= '0;
            sec_id_reg     <= '0;
            sec_end_reg    <= '0;
            entries_reg    <= '0;
            name_left_reg  <= '0;
            name_match_reg <= 1'b0;
            flags_reg      <= '0;
            rec_start_reg  <= '0;
            rec_pay_reg    <= '0;
            rec_len_reg    <= '0;
            rec_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept && in_bytes.last_byte)
                out_valid_reg <= 1'b1;
            else if (summary.ready)
                out_valid_reg <= 1'b0;
            if (in_accept)
            begin
                if (in_bytes.last_byte)
                begin
                    // module done: start over for the next one
                    pos_reg        <= '0;
                    phase_reg      <= PH_HEADER;
                    hdr_match_reg  <= 1'b1;
                    leb_reg        <= '0;
                    sec_id_reg     <= '0;
                    sec_end_reg    <= '0;
                    entries_reg    <= '0;
                    name_left_reg  <= '0;
                    name_match_reg <= 1'b0;
                    flags_reg      <= '0;
                    rec_start_reg  <= '0;
                    rec_pay_reg    <= '0;
                    rec_len_reg    <= '0;
                    rec_cnt_reg    <= '0;
                end
                else
                begin
                    pos_reg        <= pos_next;
                    phase_reg      <= phase_next;
                    hdr_match_reg  <= hdr_match_next;
                    leb_reg        <= leb_next;
                    sec_id_reg     <= sec_id_next;
                    sec_end_reg    <= sec_end_next;
                    entries_reg    <= entries_next;
                    name_left_reg  <= name_left_next;
                    name_match_reg <= name_match_next;
                    flags_reg      <= flags_next;
                    rec_start_reg  <= rec_start_next;
                    rec_pay_reg    <= rec_pay_next;
                    rec_len_reg    <= rec_len_next;
                    rec_cnt_reg    <= rec_cnt_next;
                end
            end
        end
    end

    // summary payload register
    always_ff @(posedge clk)
    begin
        if (in_accept && in_bytes.last_byte)
        begin
            summary.header_ok             <= res_hdr;
            summary.owns_memory           <= res_owns;
            summary.memory_exported       <= res_exp;
            summary.patch_needed          <= res_hdr && res_owns && !res_exp;
            summary.export_section_found  <= res_found;
            summary.export_section_start  <= res_found ? low32(rec_start_next) : 32'd0;
            summary.export_payload_start  <= res_found ? low32(rec_pay_next) : 32'd0;
            summary.export_payload_length <= res_found ? rec_len_next : 32'd0;
            summary.export_entry_count    <= res_found ? rec_cnt_next : 32'd0;
        end
    end

    assign summary.valid = out_valid_reg;

`ifndef SYNTHESIS
    a_summary_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (summary.valid && !$past(summary.valid)) |->
            $past(in_bytes.valid && in_bytes.ready && in_bytes.last_byte))
        else $error("summary appeared without a last byte");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_bytes.last_byte) |=>
            (pos_reg == '0 && phase_reg == PH_HEADER && flags_reg == '0))
        else $error("parse state not cleared after last byte");

    a_halt_without_header: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |-> !flags_reg[FL_HEADER])
        else $error("halted with header flag set");

    a_bad_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (summary.valid && !summary.header_ok) |->
            (!summary.owns_memory && !summary.memory_exported &&
             !summary.export_section_found && summary.export_entry_count == 32'd0))
        else $error("fields set on a bad header");
`endif

endmodule

`default_nettype wire

FILE: tb/wasm_memory_export_scanner_test.sv
`timescale 1ns / 100ps
// self-checking bench for the wasm memory export scanner: module bytes in, summaries out
// depends on wmes_pkg, wmes_byte_if, wmes_summary_if and wasm_memory_export_scanner

module wasm_memory_export_scanner_test;
    import wmes_pkg::*;

    localparam int TARGET_ITEMS = 1800;
    localparam int CALM_ITEMS   = 150;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [63:0] POS_MAX      = 64'h0000_0000_FFFF_FFFF;
    // byte i sits at bits 8*i+7 .. 8*i
    localparam logic [63:0] HEADER_BYTES = 64'h0000_0001_6D73_6100;
    localparam logic [47:0] NAME_BYTES   = 48'h7972_6F6D_656D;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } byte_req_t;

    typedef struct {
        logic        header_ok;
        logic        owns_memory;
        logic        memory_exported;
        logic        patch_needed;
        logic        export_section_found;
        logic [31:0] export_section_start;
        logic [31:0] export_payload_start;
        logic [31:0] export_payload_length;
        logic [31:0] export_entry_count;
    } summary_t;

    logic clk;
    logic rst_n;

    wmes_byte_if    in_bytes();
    wmes_summary_if summary();

    wasm_memory_export_scanner uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_bytes),
        .summary  (summary)
    );

    byte_req_t  byte_queue[$];
    summary_t   summary_queue[$];
    logic [7:0] mod_bytes[$];
    logic [7:0] pay_bytes[$];
    byte_req_t  next_req;

    int total_items  = 0;
    int sent_count   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int module_count = 0;

    // scanner state as the predictor sees it
    logic [63:0] scan_pos;
    phase_t      scan_phase;
    bit          hdr_match;
    logic [31:0] leb_acc;
    logic [5:0]  leb_sh;
    logic [7:0]  sec_id;
    logic [63:0] sec_end;
    logic [31:0] entries_left;
    logic [31:0] name_left;
    bit          name_ok;
    logic [3:0]  flags;
    logic [63:0] rec_start;
    logic [63:0] rec_pay_start;
    logic [63:0] rec_pay_len;
    logic [63:0] rec_count;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        if (a > POS_MAX || b > POS_MAX - a)
            return POS_MAX;
        return a + b;
    endfunction

    task automatic scan_clear();
        scan_pos      = 64'd0;
        scan_phase    = PH_HEADER;
        hdr_match     = 1'b1;
        leb_acc       = 32'd0;
        leb_sh        = 6'd0;
        sec_id        = 8'd0;
        sec_end       = 64'd0;
        entries_left  = 32'd0;
        name_left     = 32'd0;
        name_ok       = 1'b0;
        flags         = 4'd0;
        rec_start     = 64'd0;
        rec_pay_start = 64'd0;
        rec_pay_len   = 64'd0;
        rec_count     = 64'd0;
    endtask

    // one leb128 byte, saturating at 32 bits; returns 1 on the closing byte
    function automatic bit leb_take(input logic [7:0] b);
        logic [63:0] part;
        logic [63:0] t;
        part = {57'd0, b[6:0]};
        if (leb_sh < 6'd32)
        begin
            t       = {32'd0, leb_acc} | (part << leb_sh);
            leb_acc = (t[63:32] != 32'd0) ? 32'hFFFF_FFFF : t[31:0];
            leb_sh  = leb_sh + 6'd7;
        end
        else if (part != 64'd0)
        begin
            leb_acc = 32'hFFFF_FFFF;
        end
        return !b[7];
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [63:0] pos;
        summary_t    res;
        bit          done;
        bit          hdr;
        bit          found;
        int          idx;
        pos = scan_pos;
        // count reads and the entry walk never run past the declared section end
        if (scan_phase >= PH_MEM_COUNT && scan_phase <= PH_SKIP && pos >= sec_end)
            scan_phase = PH_SEC_ID;
        case (scan_phase)
            PH_HEADER:
            begin
                if (pos < 64'd8 && b != HEADER_BYTES[8 * pos[2:0] +: 8])
                    hdr_match = 1'b0;
                if (pos >= 64'd7)
                begin
                    if (hdr_match)
                    begin
                        flags[FL_HEADER] = 1'b1;
                        scan_phase = PH_SEC_ID;
                    end
                    else
                    begin
                        scan_phase = PH_HALT;
                    end
                end
            end
            PH_SEC_ID:
            begin
                // an id on the final byte cannot open a section
                if (!last)
                begin
                    sec_id     = b;
                    leb_acc    = 32'd0;
                    leb_sh     = 6'd0;
                    scan_phase = PH_SEC_LEN;
                    if (b == SEC_ID_EXPORT)
                    begin
                        flags[FL_FOUND] = 1'b1;
                        rec_start       = pos;
                        rec_pay_start   = sat_add(pos, 64'd1);
                        rec_pay_len     = 64'd0;
                        rec_count       = 64'd0;
                    end
                end
            end
            PH_SEC_LEN:
            begin
                done = leb_take(b);
                if (sec_id == SEC_ID_EXPORT)
                begin
                    rec_pay_start = sat_add(pos, 64'd1);
                    rec_pay_len   = {32'd0, leb_acc};
                end
                if (done)
                begin
                    sec_end = sat_add(sat_add(pos, 64'd1), {32'd0, leb_acc});
                    if (sec_id == SEC_ID_MEMORY)
                        scan_phase = PH_MEM_COUNT;
                    else if (sec_id == SEC_ID_EXPORT)
                        scan_phase = PH_EXP_COUNT;
                    else
                        scan_phase = PH_SKIP;
                    leb_acc = 32'd0;
                    leb_sh  = 6'd0;
                end
            end
            PH_MEM_COUNT:
            begin
                if ((b & LEB_PAYLOAD) != 8'd0)
                    flags[FL_OWNS] = 1'b1;
                if (leb_take(b))
                    scan_phase = PH_SKIP;
            end
            PH_EXP_COUNT:
            begin
                done      = leb_take(b);
                rec_count = {32'd0, leb_acc};
                if (done)
                begin
                    entries_left = leb_acc;
                    scan_phase   = (leb_acc == 32'd0) ? PH_SKIP : PH_NAME_LEN;
                    leb_acc      = 32'd0;
                    leb_sh       = 6'd0;
                end
            end
            PH_NAME_LEN:
            begin
                if (leb_take(b))
                begin
                    name_left  = leb_acc;
                    name_ok    = (leb_acc == NAME_LENGTH);
                    scan_phase = (leb_acc == 32'd0) ? PH_KIND : PH_NAME;
                    leb_acc    = 32'd0;
                    leb_sh     = 6'd0;
                end
            end
            PH_NAME:
            begin
                if (name_ok && name_left >= 32'd1 && name_left <= 32'd6)
                begin
                    idx = 6 - int'(name_left);
                    if (b != NAME_BYTES[8 * idx +: 8])
                        name_ok = 1'b0;
                end
                name_left = name_left - 32'd1;
                if (name_left == 32'd0)
                    scan_phase = PH_KIND;
            end
            PH_KIND:
            begin
                if (name_ok && b == KIND_MEMORY)
                begin
                    flags[FL_EXPORTED] = 1'b1;
                    scan_phase = PH_SKIP;
                end
                else
                begin
                    scan_phase = PH_INDEX;
                    leb_acc    = 32'd0;
                    leb_sh     = 6'd0;
                end
            end
            PH_INDEX:
            begin
                if (leb_take(b))
                begin
                    entries_left = entries_left - 32'd1;
                    scan_phase   = (entries_left == 32'd0) ? PH_SKIP : PH_NAME_LEN;
                    leb_acc      = 32'd0;
                    leb_sh       = 6'd0;
                end
            end
            default:
            begin
            end
        endcase
        scan_pos = sat_add(pos, 64'd1);

        if (last)
        begin
            hdr   = flags[FL_HEADER];
            found = hdr && flags[FL_FOUND];
            res.header_ok             = hdr;
            res.owns_memory           = hdr && flags[FL_OWNS];
            res.memory_exported       = hdr && flags[FL_EXPORTED];
            res.patch_needed          = hdr && res.owns_memory && !res.memory_exported;
            res.export_section_found  = found;
            res.export_section_start  = found ? rec_start[31:0] : 32'd0;
            res.export_payload_start  = found ? rec_pay_start[31:0] : 32'd0;
            res.export_payload_length = found ? rec_pay_len[31:0] : 32'd0;
            res.export_entry_count    = found ? rec_count[31:0] : 32'd0;
            summary_queue.insert(summary_queue.size(), res);
            scan_clear();
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic put_header();
        int i;
        for (i = 0; i < 8; i++)
            mod_bytes.insert(mod_bytes.size(), HEADER_BYTES[8 * i +: 8]);
    endtask

    // leb128 with optional redundant continuation bytes
    task automatic put_leb(input bit to_pay, input logic [31:0] v, input int pad);
        logic [7:0]  b;
        logic [31:0] rest;
        bit          done;
        rest = v;
        done = 1'b0;
        while (!done)
        begin
            b    = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (rest != 32'd0)
            begin
                b = b | LEB_CONT;
            end
            else if (pad > 0)
            begin
                b   = b | LEB_CONT;
                pad = pad - 1;
            end
            else
            begin
                done = 1'b1;
            end
            if (to_pay)
                pay_bytes.insert(pay_bytes.size(), b);
            else
                mod_bytes.insert(mod_bytes.size(), b);
        end
    endtask

    // long leb128 that can overflow or run past 32 bits of shift
    task automatic put_wide_leb(input bit to_pay);
        int         n;
        int         i;
        logic [7:0] b;
        n = $urandom_range(4, 6);
        for (i = 0; i <= n; i++)
        begin
            b = 8'($urandom_range(0, 127));
            if (i < n)
                b = b | LEB_CONT;
            else
                b = 8'($urandom_range(1, 127));
            if (to_pay)
                pay_bytes.insert(pay_bytes.size(), b);
            else
                mod_bytes.insert(mod_bytes.size(), b);
        end
    endtask

    task automatic emit_section(input logic [7:0] id);
        int len;
        int mode;
        int i;
        mod_bytes.insert(mod_bytes.size(), id);
        len  = pay_bytes.size();
        mode = $urandom_range(0, 19);
        if (mode == 0)
            put_wide_leb(1'b0);
        else if (mode == 1 && len > 0)
            put_leb(1'b0, len - $urandom_range(1, len), 0);
        else if (mode == 2)
            put_leb(1'b0, len + $urandom_range(1, 4), 0);
        else
            put_leb(1'b0, len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
        for (i = 0; i < len; i++)
            mod_bytes.insert(mod_bytes.size(), pay_bytes[i]);
        pay_bytes.delete();
    endtask

    task automatic build_memory_payload();
        int flag;
        put_leb(1'b1, $urandom_range(0, 2), ($urandom_range(0, 3) == 0) ? 1 : 0);
        flag = $urandom_range(0, 1);
        pay_bytes.insert(pay_bytes.size(), flag[7:0]);
        put_leb(1'b1, $urandom_range(0, 200), 0);
        if (flag != 0)
            put_leb(1'b1, $urandom_range(0, 300), 0);
    endtask

    task automatic build_export_payload();
        int         n;
        int         e;
        int         nm;
        int         len;
        int         i;
        int         flip;
        logic [7:0] ch;
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 15) == 0)
            put_wide_leb(1'b1);
        else
            put_leb(1'b1, n, ($urandom_range(0, 5) == 0) ? 1 : 0);
        for (e = 0; e < n; e++)
        begin
            // half the exact name, the rest near misses and random names
            nm   = $urandom_range(0, 9);
            flip = $urandom_range(0, 5);
            if (nm < 6)
                len = 6;
            else if (nm == 6)
                len = 5;
            else if (nm == 7)
                len = 7;
            else
                len = $urandom_range(0, 8);
            put_leb(1'b1, len, 0);
            for (i = 0; i < len; i++)
            begin
                ch = (i < 6) ? NAME_BYTES[8 * i +: 8] : 8'h78;
                if (nm == 5 && i == flip)
                    ch = ch ^ 8'($urandom_range(1, 255));
                if (nm >= 8)
                    ch = 8'($urandom_range(0, 255));
                pay_bytes.insert(pay_bytes.size(), ch);
            end
            if ($urandom_range(0, 3) != 0)
                pay_bytes.insert(pay_bytes.size(), KIND_MEMORY);
            else
                pay_bytes.insert(pay_bytes.size(), 8'($urandom_range(0, 255)));
            put_leb(1'b1, $urandom_range(0, 300), ($urandom_range(0, 5) == 0) ? 1 : 0);
        end
    endtask

    task automatic queue_module(input bit hold);
        int        i;
        byte_req_t r;
        for (i = 0; i < mod_bytes.size(); i++)
        begin
            r.data = mod_bytes[i];
            r.last = (i == mod_bytes.size() - 1);
            r.hold = hold && (i == 0);
            byte_queue.insert(byte_queue.size(), r);
        end
        total_items  = total_items + mod_bytes.size();
        module_count = module_count + 1;
        mod_bytes.delete();
    endtask

    task automatic gen_module();
        int         kind;
        int         nsec;
        int         s;
        int         pick;
        int         n;
        int         i;
        int         cut;
        logic [7:0] id;
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            // noise, sometimes behind a good header
            if ($urandom_range(0, 1) != 0)
                put_header();
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                mod_bytes.insert(mod_bytes.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            put_header();
            if (kind < 14)
            begin
                i = $urandom_range(0, 7);
                mod_bytes[i] = mod_bytes[i] ^ 8'($urandom_range(1, 255));
            end
            nsec = $urandom_range(0, 4);
            for (s = 0; s < nsec; s++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                begin
                    build_memory_payload();
                    emit_section(SEC_ID_MEMORY);
                end
                else if (pick < 7)
                begin
                    build_export_payload();
                    emit_section(SEC_ID_EXPORT);
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        id = 8'($urandom_range(0, 255));
                    else
                        id = 8'($urandom_range(0, 12));
                    n = $urandom_range(0, 6);
                    for (i = 0; i < n; i++)
                        pay_bytes.insert(pay_bytes.size(), 8'($urandom_range(0, 255)));
                    emit_section(id);
                end
            end
            // truncated module: ends anywhere, mid leb included
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, mod_bytes.size());
                while (mod_bytes.size() > cut)
                    void'(mod_bytes.pop_back());
            end
        end
        queue_module(module_count == 4 || $urandom_range(0, 29) == 0);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    task automatic check_summary();
        summary_t want;
        if (summary_queue.size() == 0)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("summary request with none outstanding");
        end
        else
        begin
            want = summary_queue.pop_front();
            check_field("header_ok", want.header_ok, summary.header_ok);
            check_field("owns_memory", want.owns_memory, summary.owns_memory);
            check_field("memory_exported", want.memory_exported, summary.memory_exported);
            check_field("patch_needed", want.patch_needed, summary.patch_needed);
            check_field("export_section_found", want.export_section_found,
                        summary.export_section_found);
            check_field("export_section_start", want.export_section_start,
                        summary.export_section_start);
            check_field("export_payload_start", want.export_payload_start,
                        summary.export_payload_start);
            check_field("export_payload_length", want.export_payload_length,
                        summary.export_payload_length);
            check_field("export_entry_count", want.export_entry_count,
                        summary.export_entry_count);
        end
    endtask

    // ---------------------------------------------------------------- clock, driver, monitor

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bytes.valid     <= 1'b0;
            in_bytes.data_byte <= 8'h00;
            in_bytes.last_byte <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_bytes.valid && in_bytes.ready)
            begin
                scan_byte(in_bytes.data_byte, in_bytes.last_byte);
                sent_count = sent_count + 1;
            end
            if (!in_bytes.valid || in_bytes.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_bytes.valid <= 1'b0;
                end
                else if (byte_queue.size() >= CALM_ITEMS && $urandom_range(0, 24) == 0)
                begin
                    send_gap = $urandom_range(0, 15);
                    in_bytes.valid <= 1'b0;
                end
                else if (byte_queue.size() != 0 &&
                         !(byte_queue[0].hold && summary_queue.size() != 0))
                begin
                    // a held request waits until every summary has drained
                    next_req = byte_queue.pop_front();
                    in_bytes.valid     <= 1'b1;
                    in_bytes.data_byte <= next_req.data;
                    in_bytes.last_byte <= next_req.last;
                end
                else
                begin
                    in_bytes.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary.ready <= 1'b0;
            stall_left   = 0;
            quiet_cycles = 0;
        end
        else
        begin
            if (summary.valid && summary.ready)
                check_summary();
            if ((in_bytes.valid && in_bytes.ready) || (summary.valid && summary.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                summary.ready <= 1'b0;
            end
            else if (byte_queue.size() >= CALM_ITEMS && $urandom_range(0, 19) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                summary.ready <= 1'b0;
            end
            else
            begin
                summary.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL wasm_memory_export_scanner");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        in_bytes.valid     = 1'b0;
        in_bytes.data_byte = 8'h00;
        in_bytes.last_byte = 1'b0;
        summary.ready      = 1'b0;
        scan_clear();

        // module shorter than its header
        mod_bytes.insert(mod_bytes.size(), 8'hFF);
        queue_module(1'b0);
        // wrong version byte: the trailing memory section must be ignored
        put_header();
        mod_bytes[4] = 8'h02;
        mod_bytes.insert(mod_bytes.size(), SEC_ID_MEMORY);
        mod_bytes.insert(mod_bytes.size(), 8'h01);
        mod_bytes.insert(mod_bytes.size(), 8'h01);
        queue_module(1'b0);
        // export section id on the final byte opens nothing
        put_header();
        mod_bytes.insert(mod_bytes.size(), SEC_ID_EXPORT);
        queue_module(1'b0);

        while (total_items < TARGET_ITEMS)
            gen_module();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (sent_count == total_items);
        while (summary_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && summary_queue.size() == 0)
            $display("PASS wasm_memory_export_scanner");
        else
            $display("FAIL wasm_memory_export_scanner");
        $finish;
    end

endmodule
